// ===== rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// shared widths, codes, cell control bundle and segment lookup for the
// six-digit seven-segment driver
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int FUNC_W  = 2;
    localparam int NUM_W   = 20;
    localparam int POS_W   = 3;
    localparam int GLYPH_W = 6;
    localparam int SEG_W   = 7;
    localparam int STAT_W  = 2;
    localparam int BCD_W   = 4;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SHOW  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GIVEN = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_OFF   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_GLYPH = 2'd3;

    localparam logic [GLYPH_W-1:0] GLYPH_COUNT = 6'd41;
    localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 6'd10;

    // control bundle broadcast from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic shift;
        logic finish;
    } cell_ctrl_t;

    // largest number that fits in n decimal digits
    function automatic logic [31:0] max_number(input int n);
        logic [31:0] m;
        m = 32'd1;
        for (int i = 0; i < n; i++) begin
            m = m * 32'd10;
        end
        return m - 32'd1;
    endfunction

    // segment lines a..g; decimal point bit of the table is dropped
    function automatic logic [SEG_W-1:0] seg_lookup(input logic [GLYPH_W-1:0] g);
        logic [SEG_W-1:0] s;
        unique case (g)
            6'd0:    s = 7'h3F;
            6'd1:    s = 7'h06;
            6'd2:    s = 7'h5B;
            6'd3:    s = 7'h4F;
            6'd4:    s = 7'h66;
            6'd5:    s = 7'h6D;
            6'd6:    s = 7'h7D;
            6'd7:    s = 7'h07;
            6'd8:    s = 7'h7F;
            6'd9:    s = 7'h6F;
            6'd10:   s = 7'h00;
            6'd11:   s = 7'h77;
            6'd12:   s = 7'h7C;
            6'd13:   s = 7'h39;
            6'd14:   s = 7'h5E;
            6'd15:   s = 7'h79;
            6'd16:   s = 7'h71;
            6'd17:   s = 7'h3D;
            6'd18:   s = 7'h76;
            6'd19:   s = 7'h30;
            6'd20:   s = 7'h0E;
            6'd21:   s = 7'h76;
            6'd22:   s = 7'h38;
            6'd23:   s = 7'h00;
            6'd24:   s = 7'h54;
            6'd25:   s = 7'h3F;
            6'd26:   s = 7'h73;
            6'd27:   s = 7'h67;
            6'd28:   s = 7'h50;
            6'd29:   s = 7'h6D;
            6'd30:   s = 7'h78;
            6'd31:   s = 7'h3E;
            6'd32:   s = 7'h3E;
            6'd33:   s = 7'h00;
            6'd34:   s = 7'h76;
            6'd35:   s = 7'h6E;
            6'd36:   s = 7'h5B;
            6'd37:   s = 7'h40;
            6'd38:   s = 7'h00;
            6'd39:   s = 7'h63;
            6'd40:   s = 7'h08;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/ssd_digit_cell.sv =====
// ----------------------------------------------------------------------------
// ssd_digit_cell
// one display position: holds its glyph, doubles as a bcd shift-add-3
// stage during a load, and blanks itself when it is a leading zero
// ----------------------------------------------------------------------------
module ssd_digit_cell import ssd_pkg::*; #(
    parameter logic [GLYPH_W-1:0] INIT_GLYPH = 6'd1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic               keep,
    input  logic               shift_in,
    output logic               carry_out,
    input  logic               lead_zero_in,
    output logic               lead_zero_out,
    output logic [GLYPH_W-1:0] glyph_out
);

    logic [GLYPH_W-1:0] glyph_reg;
    logic [GLYPH_W-1:0] glyph_next;
    logic [BCD_W-1:0]   bcd;
    logic [BCD_W-1:0]   adj;
    logic               is_zero;

    assign bcd     = glyph_reg[BCD_W-1:0];
    assign adj     = (bcd >= 4'd5) ? bcd + 4'd3 : bcd;
    assign is_zero = (glyph_reg == '0);

    assign carry_out     = adj[BCD_W-1];
    assign lead_zero_out = lead_zero_in & is_zero;
    assign glyph_out     = glyph_reg;

    always_comb
    begin
        glyph_next = glyph_reg;
        priority if (ctrl.clear)
        begin
            glyph_next = '0;
        end
        else if (ctrl.shift)
        begin
            glyph_next = {2'b00, adj[BCD_W-2:0], shift_in};
        end
        else if (ctrl.finish)
        begin
            // leading zero shows blank, the rightmost digit always shows
            if (lead_zero_in && is_zero && !keep)
            begin
                glyph_next = BLANK_GLYPH;
            end
        end
        else
        begin
            // idle, glyph holds
            glyph_next = glyph_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_reg <= INIT_GLYPH;
        end
        else
        begin
            glyph_reg <= glyph_next;
        end
    end

endmodule

// ===== rtl/six_digit_seven_segment_driver_core.sv =====
// ----------------------------------------------------------------------------
// six_digit_seven_segment_driver_core: multiplexed seven-segment display driver
// drive/off beats: result registered in the cycle after accept, one beat a cycle while the result is free or taken
// load beats: one number bit shifts through the cell chain per cycle (clear at
//   accept, one shift per number bit, a blanking step), no beat taken until done
// reset: glyph store holds 1,2,3,... in order, no result pending
// ----------------------------------------------------------------------------
module six_digit_seven_segment_driver_core import ssd_pkg::*; #(
    parameter int DIGITS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [NUM_W-1:0]   number,
    input  logic [POS_W-1:0]   position,
    input  logic [GLYPH_W-1:0] glyph,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIGITS-1:0]  digit_enable,
    output logic [SEG_W-1:0]   segments,
    output logic [STAT_W-1:0]  status
);

    localparam int          IDX_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int          CNT_W      = $clog2(NUM_W);
    localparam logic [31:0] MAX_NUMBER = max_number(DIGITS);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;

    logic              out_valid_reg, out_valid_next;
    logic [DIGITS-1:0] en_reg, en_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    logic accept;
    logic too_large;
    logic load_ok;

    // cell chain wiring
    cell_ctrl_t         ctrl;
    logic [DIGITS-1:0]  carry;
    logic [DIGITS-1:0]  shift_bit;
    logic [DIGITS-1:0]  lz_in;
    logic [DIGITS-1:0]  lz_out;
    logic [GLYPH_W-1:0] glyph_q [DIGITS];

    // drive decode
    logic [IDX_W-1:0]   pos_idx;
    logic               pos_bad;
    logic [GLYPH_W-1:0] glyph_sel;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign too_large = ({12'd0, number} > MAX_NUMBER);
    assign load_ok   = accept && (func == FUNC_LOAD) && !too_large;

    // clear on accept, shift while converting, blank leading zeros at the end
    assign ctrl.clear  = load_ok;
    assign ctrl.shift  = (state_reg == ST_CONV);
    assign ctrl.finish = (state_reg == ST_FIN);

    // number bits enter the rightmost cell msb first, carries walk left
    genvar i;
    generate
        for (i = 0; i < DIGITS; i++)
        begin : g_cell
            if (i == DIGITS - 1)
            begin : g_lsd
                assign shift_bit[i] = num_reg[NUM_W-1];
            end
            else
            begin : g_mid
                assign shift_bit[i] = carry[i+1];
            end

            // leading-zero flag runs from the leftmost digit rightward
            if (i == 0)
            begin : g_msd
                assign lz_in[i] = 1'b1;
            end
            else
            begin : g_rest
                assign lz_in[i] = lz_out[i-1];
            end

            ssd_digit_cell #(
                .INIT_GLYPH (GLYPH_W'(i + 1))
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .keep          (i == DIGITS - 1),
                .shift_in      (shift_bit[i]),
                .carry_out     (carry[i]),
                .lead_zero_in  (lz_in[i]),
                .lead_zero_out (lz_out[i]),
                .glyph_out     (glyph_q[i])
            );
        end
    endgenerate

    // position 1 is the leftmost cell
    assign pos_idx   = IDX_W'(position - 3'd1);
    assign pos_bad   = (position == 3'd0) || ({1'b0, position} > 4'(DIGITS));
    assign glyph_sel = (func == FUNC_SHOW) ? glyph_q[pos_idx] : glyph;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_ok)
                begin
                    state_next = ST_CONV;
                    cnt_next   = CNT_W'(NUM_W - 1);
                    num_next   = number;
                end
            end
            ST_CONV:
            begin
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register: drive beats resolve at accept, loads at the end
    always_comb
    begin
        out_valid_next = out_valid_reg;
        en_next        = en_reg;
        seg_next       = seg_reg;
        stat_next      = stat_reg;
        priority if (accept && !load_ok)
        begin
            out_valid_next = 1'b1;
            en_next        = '0;
            seg_next       = '0;
            stat_next      = STAT_OK;
            unique case (func)
                FUNC_LOAD:
                begin
                    stat_next = STAT_TOO_LARGE;
                end
                FUNC_OFF:
                begin
                    stat_next = STAT_OK;
                end
                FUNC_SHOW, FUNC_GIVEN:
                begin
                    if (pos_bad)
                    begin
                        stat_next = STAT_BAD_POS;
                    end
                    else if (glyph_sel >= GLYPH_COUNT)
                    begin
                        stat_next = STAT_BAD_GLYPH;
                    end
                    else
                    begin
                        en_next  = DIGITS'(1) << pos_idx;
                        seg_next = seg_lookup(glyph_sel);
                    end
                end
                default:
                begin
                    stat_next = STAT_OK;
                end
            endcase
        end
        else if (state_reg == ST_FIN)
        begin
            out_valid_next = 1'b1;
            en_next        = '0;
            seg_next       = '0;
            stat_next      = STAT_OK;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            // result waits for the receiver
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        en_reg   <= en_next;
        seg_reg  <= seg_next;
        stat_reg <= stat_next;
    end

    assign out_valid    = out_valid_reg;
    assign digit_enable = en_reg;
    assign segments     = seg_reg;
    assign status       = stat_reg;

    // an oversize load answers next cycle and never starts a conversion
    a_too_large: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_LOAD) && too_large)
            |=> (out_valid && (status == STAT_TOO_LARGE) && (state_reg == ST_IDLE)))
        else $error("oversize load not flagged");

    // a lit digit is always a single position with ok status
    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (digit_enable != '0)) |-> ($onehot(digit_enable) && (status == STAT_OK)))
        else $error("digit enable not one-hot");

    // a good load enters conversion and blocks further beats
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load_ok |=> ((state_reg == ST_CONV) && !in_ready))
        else $error("load did not start conversion");

    // the blanking cycle always hands a result to the output register
    a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> ((state_reg == ST_IDLE) && out_valid && (status == STAT_OK)))
        else $error("load finished without result");

endmodule

// ===== bench/segment_display_checker.sv =====
// ----------------------------------------------------------------------------
// segment_display_checker
// watches the command and result channels of the seven-segment driver,
// keeps its own copy of the glyph store, predicts each result beat and
// compares it with what the driver returns, in order
// ----------------------------------------------------------------------------
module segment_display_checker import ssd_pkg::*; #(
    parameter int DIGITS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [NUM_W-1:0]   number,
    input  logic [POS_W-1:0]   position,
    input  logic [GLYPH_W-1:0] glyph,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [DIGITS-1:0]  digit_enable,
    input  logic [SEG_W-1:0]   segments,
    input  logic [STAT_W-1:0]  status,
    output int unsigned        mismatches,
    output int unsigned        pending_beats
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUMBER_MAX = 10 ** DIGITS - 1;
    localparam int          PRINT_CAP  = 40;

    typedef struct packed {
        logic [DIGITS-1:0] enable;
        logic [SEG_W-1:0]  seg;
        logic [STAT_W-1:0] stat;
    } display_beat_t;

    logic [SEG_W-1:0]   seg_rom [0:40];
    logic [GLYPH_W-1:0] glyph_store [DIGITS];
    display_beat_t      expected_display [$];

    initial
    begin
        mismatches    = 0;
        pending_beats = 0;
        seg_rom = '{
            7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
            7'h00,
            7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30, 7'h0E,
            7'h76, 7'h38, 7'h00, 7'h54, 7'h3F, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
            7'h3E, 7'h3E, 7'h00, 7'h76, 7'h6E, 7'h5B,
            7'h40, 7'h00, 7'h63, 7'h08
        };
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // next display beat for one command, updates the glyph store on a load
    function automatic display_beat_t predict_display(
        input logic [FUNC_W-1:0]  f,
        input logic [NUM_W-1:0]   n,
        input logic [POS_W-1:0]   p,
        input logic [GLYPH_W-1:0] g
    );
        display_beat_t      r;
        logic [GLYPH_W-1:0] shown;
        int unsigned        value;
        int                 i;
        r = '0;
        r.stat = STAT_OK;
        if (f == FUNC_LOAD)
        begin
            if (n > NUMBER_MAX)
            begin
                r.stat = STAT_TOO_LARGE;
            end
            else
            begin
                for (i = 0; i < DIGITS; i++)
                    glyph_store[i] = BLANK_GLYPH;
                value = 32'(n);
                if (value == 0)
                begin
                    glyph_store[DIGITS-1] = '0;
                end
                else
                begin
                    for (i = DIGITS - 1; i >= 0 && value != 0; i--)
                    begin
                        glyph_store[i] = GLYPH_W'(value % 10);
                        value = value / 10;
                    end
                end
            end
        end
        else if (f != FUNC_OFF)
        begin
            if (p == 0 || p > DIGITS)
            begin
                r.stat = STAT_BAD_POS;
            end
            else
            begin
                shown = (f == FUNC_SHOW) ? glyph_store[p-1] : g;
                if (shown >= GLYPH_COUNT)
                begin
                    r.stat = STAT_BAD_GLYPH;
                end
                else
                begin
                    r.enable[p-1] = 1'b1;
                    r.seg = seg_rom[shown];
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        display_beat_t want;
        int            k;
        if (!rst_n)
        begin
            for (k = 0; k < DIGITS; k++)
                glyph_store[k] = GLYPH_W'(k + 1);
            expected_display.delete();
            pending_beats <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_display.push_back(predict_display(func, number, position, glyph));
            if (out_valid && out_ready)
            begin
                if (expected_display.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat en=%h seg=%h st=%0d",
                                              digit_enable, segments, status));
                end
                else
                begin
                    want = expected_display.pop_front();
                    if (digit_enable !== want.enable || segments !== want.seg ||
                        status !== want.stat)
                        report_mismatch($sformatf(
                            "en=%h seg=%h st=%0d, expected en=%h seg=%h st=%0d",
                            digit_enable, segments, status,
                            want.enable, want.seg, want.stat));
                end
            end
            pending_beats <= expected_display.size();
        end
    end

endmodule

// ===== bench/six_digit_seven_segment_driver_core_test.sv =====
// ----------------------------------------------------------------------------
// six_digit_seven_segment_driver_core_test
// drives load, show, given-glyph and off commands into the display driver,
// first a directed set of corner cases, then random commands with idle
// bursts on both channels, a long result hold-off and a drain pause; the
// checker beside the driver predicts and compares every result beat
// ----------------------------------------------------------------------------
module six_digit_seven_segment_driver_core_test import ssd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGIT_COUNT = 6;
    localparam int CYCLE_LIMIT = 400000;   // far above the slowest passing run
    localparam int LONG_HOLD   = 300;      // receiver hold-off, fills the driver
    localparam int SETTLE      = 40;       // settle after the final drain

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func;
    logic [NUM_W-1:0]       number;
    logic [POS_W-1:0]       position;
    logic [GLYPH_W-1:0]     glyph;
    logic                   out_valid;
    logic                   out_ready;
    logic [DIGIT_COUNT-1:0] digit_enable;
    logic [SEG_W-1:0]       segments;
    logic [STAT_W-1:0]      status;

    int unsigned mismatches;
    int unsigned pending_beats;
    int unsigned cycle_count = 0;
    int          hold_asked  = 0;   // bumped by the sender to ask for a long hold
    bit          quiet       = 1'b0; // no idling on either side once set

    six_digit_seven_segment_driver_core #(
        .DIGITS(DIGIT_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .number      (number),
        .position    (position),
        .glyph       (glyph),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit_enable(digit_enable),
        .segments    (segments),
        .status      (status)
    );

    segment_display_checker #(
        .DIGITS(DIGIT_COUNT)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .number       (number),
        .position     (position),
        .glyph        (glyph),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_enable (digit_enable),
        .segments     (segments),
        .status       (status),
        .mismatches   (mismatches),
        .pending_beats(pending_beats)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, a hung handshake ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stall bursts, plus a long hold whenever the sender asks
    initial
    begin : result_sink
        int hold_done;
        int stall;
        hold_done = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_done)
            begin
                hold_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 17);
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // offer one command beat and hold it until the driver takes it;
    // valid is left high so a following beat goes out back to back
    task automatic send_beat(
        input logic [FUNC_W-1:0]  f,
        input logic [NUM_W-1:0]   n,
        input logic [POS_W-1:0]   p,
        input logic [GLYPH_W-1:0] g
    );
        in_valid <= 1'b1;
        func     <= f;
        number   <= n;
        position <= p;
        glyph    <= g;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // wait until every predicted beat has come back; the first edge lets
    // the checker count a beat accepted at the current edge
    task automatic wait_drained();
        do @(posedge clk); while (pending_beats != 0);
    endtask

    // random commands, mostly well formed, some bad positions, bad glyphs
    // and numbers past the six-digit limit
    task automatic run_random(input int count);
        logic [FUNC_W-1:0]  f;
        logic [NUM_W-1:0]   n;
        logic [POS_W-1:0]   p;
        logic [GLYPH_W-1:0] g;
        int                 pick;
        int                 gap;
        int                 k;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                f = FUNC_LOAD;
            else if (pick < 5)
                f = FUNC_SHOW;
            else if (pick < 9)
                f = FUNC_GIVEN;
            else
                f = FUNC_OFF;
            // spread numbers over every digit count and around the limit
            case ($urandom_range(0, 3))
                0:       n = NUM_W'($urandom % (10 ** $urandom_range(1, 6)));
                1:       n = NUM_W'($urandom_range(0, 999999));
                2:       n = NUM_W'($urandom_range(999990, 1000010));
                default: n = NUM_W'($urandom);
            endcase
            if ($urandom_range(0, 7) == 0)
                p = POS_W'($urandom);
            else
                p = POS_W'($urandom_range(1, DIGIT_COUNT));
            if ($urandom_range(0, 5) == 0)
                g = GLYPH_W'($urandom);
            else
                g = GLYPH_W'($urandom_range(0, 40));
            send_beat(f, n, p, g);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                gap = $urandom_range(1, 17);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = FUNC_OFF;
        number   = '0;
        position = '0;
        glyph    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // glyphs left by reset
        send_beat(FUNC_SHOW,  '0,          3'd1, '0);
        send_beat(FUNC_SHOW,  '0,          3'd6, '0);
        // bad position, and bad position wins over a bad glyph
        send_beat(FUNC_SHOW,  '0,          3'd0, '0);
        send_beat(FUNC_GIVEN, '0,          3'd7, 6'd63);
        // table ends, bad glyph, period drives nothing
        send_beat(FUNC_GIVEN, '0,          3'd3, 6'd0);
        send_beat(FUNC_GIVEN, '0,          3'd3, 6'd40);
        send_beat(FUNC_GIVEN, '0,          3'd2, 6'd41);
        send_beat(FUNC_GIVEN, '0,          3'd4, 6'd38);
        send_beat(FUNC_GIVEN, '0,          3'd5, 6'd63);
        // all off ignores the other fields
        send_beat(FUNC_OFF,   20'hFFFFF,   3'd7, 6'd63);
        // zero shows a single 0 on the right, the rest blank
        send_beat(FUNC_LOAD,  20'd0,       3'd0, '0);
        send_beat(FUNC_SHOW,  '0,          3'd6, '0);
        send_beat(FUNC_SHOW,  '0,          3'd5, '0);
        // largest number, then too large ones leave the store alone
        send_beat(FUNC_LOAD,  20'd999999,  3'd0, '0);
        send_beat(FUNC_SHOW,  '0,          3'd1, '0);
        send_beat(FUNC_LOAD,  20'd1000000, 3'd0, '0);
        send_beat(FUNC_SHOW,  '0,          3'd1, '0);
        send_beat(FUNC_LOAD,  20'hFFFFF,   3'd0, '0);
        send_beat(FUNC_SHOW,  '0,          3'd6, '0);
        // single digit and leading zeros inside the number
        send_beat(FUNC_LOAD,  20'd7,       3'd0, '0);
        send_beat(FUNC_SHOW,  '0,          3'd1, '0);
        send_beat(FUNC_SHOW,  '0,          3'd6, '0);
        send_beat(FUNC_LOAD,  20'd100000,  3'd0, '0);
        send_beat(FUNC_SHOW,  '0,          3'd2, '0);

        run_random(230);

        // long result hold while commands keep coming, the driver backs up
        hold_asked <= hold_asked + 1;
        run_random(40);

        // sender pause until every result is back
        in_valid <= 1'b0;
        wait_drained();

        run_random(180);

        // closing stretch with no idling on either side
        quiet = 1'b1;
        run_random(80);
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && pending_beats == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
